FILE: src/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion macros shared by the RTL; empty under SYNTHESIS.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define LWN_ASSERT(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("assertion failed");
`define LWN_NEVER(label, clk, rst, expr) \
   label: assert property (@(posedge clk) disable iff (rst) !(expr)) \
      else $error("forbidden condition seen");
`else
`define LWN_ASSERT(label, clk, rst, prop)
`define LWN_NEVER(label, clk, rst, expr)
`endif
`endif

FILE: src/lwn_pkg.sv
// ----------------------------------------------------------------------------
// lwn_pkg
// Widths, exponential factor table and shared types of the weight normalizer.
// ----------------------------------------------------------------------------
package lwn_pkg;

   localparam int MAX_ITEMS   = 64;
   localparam int STORE_DEPTH = 64;
   localparam int ADDR_W      = 6;
   localparam int CNT_W       = 7;
   localparam int LW_W        = 24;
   localparam int W_W         = 17;
   localparam int SUM_W       = 23;
   localparam int EXP_BITS    = 20;
   localparam int K_W         = 5;
   localparam int T_W         = 25;
   localparam int ACC_W       = 33;
   localparam int FACT_W      = 32;

   localparam logic signed [LW_W-1:0] MIN_LW = {1'b1, {(LW_W-1){1'b0}}};

   typedef logic [EXP_BITS-1:0][FACT_W-1:0] factor_table_type;

   // exp(-2^(k-16)) in Q0.32, from an alternating series kept in Q50
   function automatic factor_table_type build_factors();
      factor_table_type tbl;
      logic [63:0]      term;
      logic [63:0]      sum;
      int               j;
      for (int k = 0; k < EXP_BITS; k++) begin
         j    = k - 16;
         term = 64'd1 << 50;
         sum  = term;
         for (int n = 1; n <= 60; n++) begin
            if (j >= 0) begin
               term = (term << j) / 64'(n);
            end else begin
               term = (term >> (-j)) / 64'(n);
            end
            if ((n % 2) == 1) begin
               sum = sum - term;
            end else begin
               sum = sum + term;
            end
         end
         tbl[k] = FACT_W'((sum + (64'd1 << 17)) >> 18);
      end
      return tbl;
   endfunction

   localparam factor_table_type EXP_FACTOR = build_factors();

   typedef struct packed {
      logic           start;
      logic [T_W-1:0] t;
   } exp_req_type;

   typedef struct packed {
      logic           busy;
      logic           done;
      logic [W_W-1:0] weight;
   } exp_sts_type;

endpackage

FILE: src/lwn_channels.sv
// ----------------------------------------------------------------------------
// lwn_channels
// Valid/ready channels for log weight words and normalized weight words.
// ----------------------------------------------------------------------------
interface lwn_req_if;
   logic                                   valid;
   logic                                   ready;
   logic signed [lwn_pkg::LW_W-1:0]        log_weight;
   logic                                   last_item;

   modport source (output valid, output log_weight, output last_item, input ready);
   modport sink   (input valid, input log_weight, input last_item, output ready);
endinterface

interface lwn_rsp_if;
   logic                                   valid;
   logic                                   ready;
   logic [lwn_pkg::W_W-1:0]                weight;
   logic [lwn_pkg::ADDR_W-1:0]             item_index;
   logic [lwn_pkg::SUM_W-1:0]              weight_sum;
   logic signed [lwn_pkg::LW_W-1:0]        max_log_weight;
   logic                                   final_result;

   modport source (output valid, output weight, output item_index, output weight_sum,
                   output max_log_weight, output final_result, input ready);
   modport sink   (input valid, input weight, input item_index, input weight_sum,
                   input max_log_weight, input final_result, output ready);
endinterface

FILE: src/lwn_ram.sv
// ----------------------------------------------------------------------------
// lwn_ram
// Generic single-write, single-read synchronous RAM with registered read.
// ----------------------------------------------------------------------------
module lwn_ram #(
   parameter int WIDTH = 24,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;
endmodule

FILE: src/lwn_exp.sv
// ----------------------------------------------------------------------------
// lwn_exp
// Iterative exp(-t) in Q1.16: one factor multiply per cycle over the bits of t.
// ----------------------------------------------------------------------------
module lwn_exp (
   input  logic                 clock,
   input  logic                 reset,
   input  lwn_pkg::exp_req_type req,
   output lwn_pkg::exp_sts_type sts
);
   logic                        busy_ff, busy_in;
   logic                        done_ff, done_in;
   logic [lwn_pkg::K_W-1:0]     k_ff, k_in;
   logic [lwn_pkg::T_W-1:0]     t_ff, t_in;
   logic [lwn_pkg::ACC_W-1:0]   acc_ff, acc_in;
   logic [lwn_pkg::ACC_W+lwn_pkg::FACT_W-1:0] prod;
   logic [lwn_pkg::ACC_W-1:0]   rounded;
   logic [lwn_pkg::ACC_W-1:0]   acc_half;

   assign prod    = acc_ff * lwn_pkg::EXP_FACTOR[k_ff];
   assign rounded = lwn_pkg::ACC_W'((prod + (65'd1 << 31)) >> 32);

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      k_in    = k_ff;
      t_in    = t_ff;
      acc_in  = acc_ff;
      if (req.start) begin
         busy_in = 1'b1;
         k_in    = '0;
         t_in    = req.t;
         acc_in  = lwn_pkg::ACC_W'(64'd1 << 32);
      end else if (busy_ff) begin
         // advance one bit of t; multiply in its factor when set
         if (t_ff[k_ff]) begin
            acc_in = rounded;
         end
         k_in = k_ff + 1'b1;
         if (k_ff == lwn_pkg::K_W'(lwn_pkg::EXP_BITS - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      k_ff   <= k_in;
      t_ff   <= t_in;
      acc_ff <= acc_in;
   end

   assign acc_half   = acc_ff + lwn_pkg::ACC_W'(32768);
   assign sts.busy   = busy_ff;
   assign sts.done   = done_ff;
   // drop to zero for a difference of 16 or more
   assign sts.weight = (|t_ff[lwn_pkg::T_W-1:lwn_pkg::EXP_BITS]) ? '0
                       : acc_half[lwn_pkg::W_W+15:16];
endmodule

FILE: src/log_weight_normalizer_unit.sv
// ----------------------------------------------------------------------------
// log_weight_normalizer_unit
// Log-sum-exp weight normalization: load a set of log weights, then emit
// exp(log weight - max) per weight, with the sum and max on the final word.
// ----------------------------------------------------------------------------
//  channel  dir  word
//  req_if   in   log_weight (s24 Q8.16), last_item
//  rsp_if   out  weight (Q1.16), item_index, weight_sum, max_log_weight, final_result
//
//  Loading accepts one word per cycle in the load state; the store write and
//  running max update happen in the accept cycle. The emit pass handles each
//  stored weight in steps: a RAM read, a start step, twenty steps of the shared
//  factor multiplier in lwn_exp plus a step that sees its done flag, and one
//  push into the output register. Reset is synchronous; it clears the set
//  count and the output valid and sets the running max to its minimum.
//  req_if.ready is low during the emit pass; a stalled output word holds the
//  pass at the push step. Loading of the next set starts as soon as the final
//  word sits in the output register.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module log_weight_normalizer_unit (
   input  logic       clock,
   input  logic       reset,
   lwn_req_if.sink    req_if,
   lwn_rsp_if.source  rsp_if
);
   logic [2:0]                         state_ff, state_in;
   localparam logic [2:0] S_LOAD = 3'd0;
   localparam logic [2:0] S_READ = 3'd1;
   localparam logic [2:0] S_WAIT = 3'd2;
   localparam logic [2:0] S_EXP  = 3'd3;
   localparam logic [2:0] S_PUSH = 3'd4;

   logic [lwn_pkg::CNT_W-1:0]          count_ff, count_in;
   logic [lwn_pkg::ADDR_W-1:0]         idx_ff, idx_in;
   logic signed [lwn_pkg::LW_W-1:0]    max_ff, max_in;
   logic [lwn_pkg::SUM_W-1:0]          sum_ff, sum_in;

   logic                               out_valid_ff, out_valid_in;
   logic [lwn_pkg::W_W-1:0]            out_weight_ff, out_weight_in;
   logic [lwn_pkg::ADDR_W-1:0]         out_index_ff, out_index_in;
   logic [lwn_pkg::SUM_W-1:0]          out_sum_ff, out_sum_in;
   logic signed [lwn_pkg::LW_W-1:0]    out_max_ff, out_max_in;
   logic                               out_final_ff, out_final_in;

   logic                               req_take;
   logic                               wr_en;
   logic [lwn_pkg::LW_W-1:0]           rd_data;
   logic signed [lwn_pkg::LW_W-1:0]    rd_lw;
   logic [lwn_pkg::SUM_W-1:0]          sum_next;
   logic                               last_weight;
   logic                               out_free;
   lwn_pkg::exp_req_type               exp_req;
   lwn_pkg::exp_sts_type               exp_sts;

   assign req_if.ready = (state_ff == S_LOAD);
   assign req_take     = req_if.valid && req_if.ready;
   // drop words that arrive with the set full
   assign wr_en        = req_take && (count_ff < lwn_pkg::CNT_W'(lwn_pkg::MAX_ITEMS));

   lwn_ram #(
      .WIDTH(lwn_pkg::LW_W),
      .DEPTH(lwn_pkg::STORE_DEPTH)
   ) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (count_ff[lwn_pkg::ADDR_W-1:0]),
      .wr_data (req_if.log_weight),
      .rd_addr (idx_ff),
      .rd_data (rd_data)
   );

   assign rd_lw       = rd_data;
   assign exp_req.start = (state_ff == S_WAIT);
   // max is never below a stored weight, so the difference is non-negative
   assign exp_req.t   = lwn_pkg::T_W'({max_ff[lwn_pkg::LW_W-1], max_ff}
                                      - {rd_lw[lwn_pkg::LW_W-1], rd_lw});

   lwn_exp u_exp (
      .clock (clock),
      .reset (reset),
      .req   (exp_req),
      .sts   (exp_sts)
   );

   assign sum_next    = sum_ff + lwn_pkg::SUM_W'(exp_sts.weight);
   assign last_weight = (lwn_pkg::CNT_W'(idx_ff) + 1'b1 == count_ff);
   assign out_free    = !out_valid_ff || rsp_if.ready;

   always_comb begin
      state_in      = state_ff;
      count_in      = count_ff;
      idx_in        = idx_ff;
      max_in        = max_ff;
      sum_in        = sum_ff;
      out_valid_in  = out_valid_ff && !rsp_if.ready;
      out_weight_in = out_weight_ff;
      out_index_in  = out_index_ff;
      out_sum_in    = out_sum_ff;
      out_max_in    = out_max_ff;
      out_final_in  = out_final_ff;
      unique case (state_ff)
         S_LOAD: begin
            if (wr_en) begin
               count_in = count_ff + 1'b1;
               if (req_if.log_weight > max_ff) begin
                  max_in = req_if.log_weight;
               end
            end
            if (req_take && req_if.last_item) begin
               idx_in   = '0;
               sum_in   = '0;
               state_in = S_READ;
            end
         end
         S_READ: begin
            state_in = S_WAIT;
         end
         S_WAIT: begin
            state_in = S_EXP;
         end
         S_EXP: begin
            if (exp_sts.done) begin
               state_in = S_PUSH;
            end
         end
         S_PUSH: begin
            // hold until the output register frees up
            if (out_free) begin
               out_valid_in  = 1'b1;
               out_weight_in = exp_sts.weight;
               out_index_in  = idx_ff;
               out_final_in  = last_weight;
               out_sum_in    = last_weight ? sum_next : '0;
               out_max_in    = last_weight ? max_ff : '0;
               sum_in        = sum_next;
               if (last_weight) begin
                  count_in = '0;
                  max_in   = lwn_pkg::MIN_LW;
                  sum_in   = '0;
                  state_in = S_LOAD;
               end else begin
                  idx_in   = idx_ff + 1'b1;
                  state_in = S_READ;
               end
            end
         end
         default: begin
            state_in = S_LOAD;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_LOAD;
         count_ff     <= '0;
         max_ff       <= lwn_pkg::MIN_LW;
         sum_ff       <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         max_ff       <= max_in;
         sum_ff       <= sum_in;
         out_valid_ff <= out_valid_in;
      end
      idx_ff        <= idx_in;
      out_weight_ff <= out_weight_in;
      out_index_ff  <= out_index_in;
      out_sum_ff    <= out_sum_in;
      out_max_ff    <= out_max_in;
      out_final_ff  <= out_final_in;
   end

   assign rsp_if.valid          = out_valid_ff;
   assign rsp_if.weight         = out_weight_ff;
   assign rsp_if.item_index     = out_index_ff;
   assign rsp_if.weight_sum     = out_sum_ff;
   assign rsp_if.max_log_weight = out_max_ff;
   assign rsp_if.final_result   = out_final_ff;

   // the set never grows past its capacity
   `LWN_ASSERT(a_count_bound, clock, reset, count_ff <= lwn_pkg::CNT_W'(lwn_pkg::MAX_ITEMS))
   // no load is taken while the exponential unit works
   `LWN_NEVER(a_no_load_in_emit, clock, reset, req_if.ready && exp_sts.busy)
   // the exponential finishes only while the sequencer waits for it
   `LWN_ASSERT(a_done_in_exp, clock, reset, exp_sts.done |-> state_ff == S_EXP)
   // an emit pass never starts on an empty set
   `LWN_NEVER(a_emit_nonempty, clock, reset, state_ff == S_READ && count_ff == '0)

endmodule
